// ----- rtl/core/rar_pkg.sv -----
package rar_pkg;

  localparam int RES_W   = 32;
  localparam int OPW_DEF = 16;
  localparam int CNT_W   = $clog2(RES_W);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_DIV = 2'd2;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_OPND_ZERO = 2'd1,
    STS_DEN_ZERO  = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    PS_AD,
    PS_BC,
    PS_BD
  } prod_sel_t;

  typedef enum logic [1:0] {
    DS_EUC,
    DS_NUM,
    DS_DEN
  } div_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_AD,
    S_MUL_BC,
    S_MUL_BD,
    S_MUL_ACC,
    S_CHECK,
    S_EUC_LOAD,
    S_EUC_DIV,
    S_EUC_NEXT,
    S_QN_LOAD,
    S_QN_DIV,
    S_QD_LOAD,
    S_QD_DIV,
    S_QD_END,
    S_WRITE
  } rar_state_t;

  typedef struct packed {
    logic      load;
    logic      mul_en;
    prod_sel_t mul_sel;
    logic      acc_en;
    prod_sel_t acc_sel;
    logic      check;
    logic      div_load;
    div_src_t  div_src;
    logic      div_step;
    logic      euc_shift;
    logic      quo_en;
    div_src_t  quo_dst;
    logic      write;
  } rar_cmd_t;

  typedef struct packed {
    logic opnd_zero;
    logic q_zero;
    logic rem_zero;
  } rar_sts_t;

endpackage

// ----- rtl/core/rar_datapath.sv -----
module rar_datapath
  import rar_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rar_cmd_t                        cmd,
  output rar_sts_t                        sts,
  input  logic [1:0]                      opcode,
  input  logic signed [OPERAND_WIDTH-1:0] first_num,
  input  logic signed [OPERAND_WIDTH-1:0] first_den,
  input  logic signed [OPERAND_WIDTH-1:0] second_num,
  input  logic signed [OPERAND_WIDTH-1:0] second_den,
  output logic signed [RES_W-1:0]         result_num,
  output logic signed [RES_W-1:0]         result_den,
  output logic [1:0]                      status
);

  function automatic logic [RES_W-1:0] mag(input logic [RES_W-1:0] x);
    mag = x[RES_W-1] ? -x : x;
  endfunction

  logic [1:0]                      op;
  logic signed [OPERAND_WIDTH-1:0] a;
  logic signed [OPERAND_WIDTH-1:0] b;
  logic signed [OPERAND_WIDTH-1:0] c;
  logic signed [OPERAND_WIDTH-1:0] d;
  logic                            opnd_zero;
  logic [RES_W-1:0]                a_ext, b_ext, c_ext, d_ext;
  logic [RES_W-1:0]                mul_x, mul_y;
  logic [RES_W-1:0]                prod;
  logic [RES_W-1:0]                n;
  logic [RES_W-1:0]                q;
  logic [RES_W-1:0]                num_mag;
  logic                            num_neg;
  logic [RES_W-1:0]                den_mag;
  logic                            den_neg;
  logic [RES_W-1:0]                dv_quo;
  logic [RES_W-1:0]                dv_rem;
  logic [RES_W:0]                  rem_sh;
  logic [RES_W:0]                  diff;
  logic [RES_W-1:0]                dividend;
  logic                            quo_neg;
  logic [RES_W-1:0]                quo_val;
  logic [RES_W-1:0]                rn;
  logic [RES_W-1:0]                rd;
  status_code_t                    rs;

  assign a_ext = RES_W'(a);
  assign b_ext = RES_W'(b);
  assign c_ext = RES_W'(c);
  assign d_ext = RES_W'(d);

  always_comb begin
    case (cmd.mul_sel)
      PS_AD: begin
        mul_x = a_ext;
        mul_y = d_ext;
      end
      PS_BC: begin
        mul_x = b_ext;
        mul_y = c_ext;
      end
      default: begin
        mul_x = b_ext;
        mul_y = d_ext;
      end
    endcase
  end

  always_comb begin
    case (cmd.div_src)
      DS_EUC:  dividend = num_mag;
      DS_NUM:  dividend = mag(n);
      default: dividend = mag(q);
    endcase
  end

  assign rem_sh  = {dv_rem, dv_quo[RES_W-1]};
  assign diff    = rem_sh - {1'b0, den_mag};
  assign quo_neg = ((cmd.quo_dst == DS_NUM) ? n[RES_W-1] : q[RES_W-1]) ^ den_neg;
  assign quo_val = quo_neg ? -dv_quo : dv_quo;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= opcode;
      a         <= first_num;
      b         <= first_den;
      c         <= second_num;
      d         <= second_den;
      opnd_zero <= (opcode == OP_ADD || opcode == OP_SUB) &&
                   (first_den == '0 || second_den == '0);
    end
    if (cmd.mul_en) begin
      prod <= mul_x * mul_y;
    end
    if (cmd.acc_en) begin
      case (cmd.acc_sel)
        PS_AD: n <= prod;
        PS_BC: begin
          case (op)
            OP_ADD:  n <= n + prod;
            OP_SUB:  n <= n - prod;
            default: q <= prod;
          endcase
        end
        default: begin
          if (op == OP_ADD || op == OP_SUB) begin
            q <= prod;
          end
        end
      endcase
    end
    if (cmd.check) begin
      num_mag <= mag(n);
      num_neg <= n[RES_W-1];
      den_mag <= mag(q);
      den_neg <= q[RES_W-1];
      if (opnd_zero) begin
        rn <= '0;
        rd <= '0;
      end else if (q == '0) begin
        rn <= n;
        rd <= '0;
      end
    end
    if (cmd.div_load) begin
      dv_quo <= dividend;
      dv_rem <= '0;
    end else if (cmd.div_step) begin
      dv_quo <= {dv_quo[RES_W-2:0], ~diff[RES_W]};
      dv_rem <= diff[RES_W] ? rem_sh[RES_W-1:0] : diff[RES_W-1:0];
    end
    if (cmd.euc_shift) begin
      num_mag <= den_mag;
      num_neg <= den_neg;
      den_mag <= dv_rem;
      den_neg <= num_neg;
    end
    if (cmd.quo_en) begin
      if (cmd.quo_dst == DS_NUM) begin
        rn <= quo_val;
      end else begin
        rd <= quo_val;
      end
    end
    if (cmd.write) begin
      result_num <= rn;
      result_den <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rs     <= STS_OK;
      status <= STS_OK;
    end else begin
      if (cmd.check) begin
        if (opnd_zero) begin
          rs <= STS_OPND_ZERO;
        end else if (q == '0) begin
          rs <= STS_DEN_ZERO;
        end else begin
          rs <= STS_OK;
        end
      end
      if (cmd.write) begin
        status <= rs;
      end
    end
  end

  assign sts.opnd_zero = opnd_zero;
  assign sts.q_zero    = (q == '0);
  assign sts.rem_zero  = (dv_rem == '0);

`ifndef SYNTH
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> den_mag != '0)
    else $error("divide step with zero divisor");

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    cmd.euc_shift |-> dv_rem < den_mag)
    else $error("euclid remainder not below divisor");
`endif

endmodule

// ----- rtl/core/rar_ctrl.sv -----
module rar_ctrl
  import rar_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  rar_sts_t sts,
  output rar_cmd_t cmd
);

  rar_state_t       state, state_next;
  logic [CNT_W-1:0] count;
  logic             last_step;
  logic             out_free;

  assign last_step = (count == CNT_W'(RES_W - 1));
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (req_valid) state_next = S_MUL_AD;
      S_MUL_AD:   state_next = S_MUL_BC;
      S_MUL_BC:   state_next = S_MUL_BD;
      S_MUL_BD:   state_next = S_MUL_ACC;
      S_MUL_ACC:  state_next = S_CHECK;
      S_CHECK: begin
        if (sts.opnd_zero || sts.q_zero) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_EUC_LOAD;
        end
      end
      S_EUC_LOAD: state_next = S_EUC_DIV;
      S_EUC_DIV:  if (last_step) state_next = S_EUC_NEXT;
      S_EUC_NEXT: begin
        if (sts.rem_zero) begin
          state_next = S_QN_LOAD;
        end else begin
          state_next = S_EUC_LOAD;
        end
      end
      S_QN_LOAD:  state_next = S_QN_DIV;
      S_QN_DIV:   if (last_step) state_next = S_QD_LOAD;
      S_QD_LOAD:  state_next = S_QD_DIV;
      S_QD_DIV:   if (last_step) state_next = S_QD_END;
      S_QD_END:   state_next = S_WRITE;
      S_WRITE:    if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_sel = PS_AD;
    cmd.acc_sel = PS_AD;
    cmd.div_src = DS_EUC;
    cmd.quo_dst = DS_NUM;
    case (state)
      S_IDLE: cmd.load = req_valid;
      S_MUL_AD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = PS_AD;
      end
      S_MUL_BC: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = PS_BC;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = PS_AD;
      end
      S_MUL_BD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = PS_BD;
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = PS_BC;
      end
      S_MUL_ACC: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sel = PS_BD;
      end
      S_CHECK: cmd.check = 1'b1;
      S_EUC_LOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DS_EUC;
      end
      S_EUC_DIV:  cmd.div_step = 1'b1;
      S_EUC_NEXT: cmd.euc_shift = !sts.rem_zero;
      S_QN_LOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DS_NUM;
      end
      S_QN_DIV:   cmd.div_step = 1'b1;
      S_QD_LOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = DS_DEN;
        cmd.quo_en   = 1'b1;
        cmd.quo_dst  = DS_NUM;
      end
      S_QD_DIV:   cmd.div_step = 1'b1;
      S_QD_END: begin
        cmd.quo_en  = 1'b1;
        cmd.quo_dst = DS_DEN;
      end
      S_WRITE:    cmd.write = out_free;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_load) begin
        count <= '0;
      end else if (cmd.div_step) begin
        count <= count + 1'b1;
      end
      if (cmd.write) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state == S_MUL_AD)
    else $error("accepted transaction did not start the multiply sequence");

  a_rsp_from_write: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_WRITE)
    else $error("response raised outside the write state");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EUC_LOAD || state == S_QN_LOAD || state == S_QD_LOAD) |=> count == '0)
    else $error("divider step count not cleared on load");
`endif

endmodule

// ----- rtl/core/rational_arith_reduce_top.sv -----
// sequence: after accept, the multiply and accumulate states and a check go to write
// on a zero operand or result denominator, else to euclid steps and both final divisions
// flow: one transaction in flight; the next is taken while the last result waits
// the 32-step radix-2 divider is shared by euclid and both final divisions
// reset: synchronous active-high rst returns the controller to idle and drops rsp_valid
module rational_arith_reduce_top
  import rar_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [1:0]                      opcode,
  input  logic signed [OPERAND_WIDTH-1:0] first_num,
  input  logic signed [OPERAND_WIDTH-1:0] first_den,
  input  logic signed [OPERAND_WIDTH-1:0] second_num,
  input  logic signed [OPERAND_WIDTH-1:0] second_den,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic signed [RES_W-1:0]         result_num,
  output logic signed [RES_W-1:0]         result_den,
  output logic [1:0]                      status
);

  rar_cmd_t cmd;
  rar_sts_t sts;

  rar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rar_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .first_num  (first_num),
    .first_den  (first_den),
    .second_num (second_num),
    .second_den (second_den),
    .result_num (result_num),
    .result_den (result_den),
    .status     (status)
  );

endmodule
